FILE: rtl/ctv_pkg.sv
// ----------------------------------------------------------------------------
// ctv_pkg
// Shared types and constants for the checkpoint table validator.
// ----------------------------------------------------------------------------
package ctv_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int HEIGHT_W          = 32;
    localparam int HASH_W            = 256;
    localparam int HASH_WORD_W       = 64;
    localparam int FD_W              = 16;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic [FD_W-1:0] FD_RESET = 16'd10;

    // register index, paddr[APB_ADDR_W-1:2]
    localparam logic [APB_ADDR_W-3:0] REG_FINALITY_DEPTH = 1'b0;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CHECK = 2'd1,
        FUNC_ALT   = 2'd2,
        FUNC_RSVD  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REASON_NONE     = 3'd0,
        REASON_DUP      = 3'd1,
        REASON_FULL     = 3'd2,
        REASON_MISMATCH = 3'd3,
        REASON_GENESIS  = 3'd4,
        REASON_DEEP     = 3'd5,
        REASON_BELOW_CP = 3'd6
    } t_reason;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HASH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    ok;
        logic    is_checkpoint;
        logic    in_zone;
        t_reason reason;
    } t_result;

endpackage

FILE: rtl/ctv_if.sv
// ----------------------------------------------------------------------------
// ctv_in_if / ctv_out_if
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
interface ctv_in_if import ctv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_func                  func;
    logic [HEIGHT_W-1:0]    blk_height;
    logic [HEIGHT_W-1:0]    chain_height;
    logic [HASH_WORD_W-1:0] hash_w0;
    logic [HASH_WORD_W-1:0] hash_w1;
    logic [HASH_WORD_W-1:0] hash_w2;
    logic [HASH_WORD_W-1:0] hash_w3;

    modport source (
        output valid, func, blk_height, chain_height,
               hash_w0, hash_w1, hash_w2, hash_w3,
        input  ready
    );
    modport sink (
        input  valid, func, blk_height, chain_height,
               hash_w0, hash_w1, hash_w2, hash_w3,
        output ready
    );
endinterface

interface ctv_out_if import ctv_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    ok;
    logic    is_checkpoint;
    logic    in_zone;
    t_reason reason;

    modport source (
        output valid, ok, is_checkpoint, in_zone, reason,
        input  ready
    );
    modport sink (
        input  valid, ok, is_checkpoint, in_zone, reason,
        output ready
    );
endinterface

FILE: rtl/checkpoint_table_validator.sv
// ----------------------------------------------------------------------------
// checkpoint_table_validator
// Checkpoint table: add, hash check and alternative-block test.
//
//   channel  dir  handshake          contents
//   i_in     in   valid/ready        func, heights, 256-bit hash
//   o_out    out  valid/ready        ok, is_checkpoint, in_zone, reason
//   apb      in   psel/penable       finality_depth at 0x0
//
// An item passes the scan state, the hash state for a check that hits a
// checkpoint, and the done state; the height memory is scanned one read per
// cycle. Reset empties the table through the entry count, with no clearing
// pass; finality_depth resets to 10. A finished word waits in the done state
// until the output register is free; the output register holds while
// o_out.ready is low.
// ----------------------------------------------------------------------------
module checkpoint_table_validator import ctv_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ctv_in_if.sink                i_in,
    ctv_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    t_state              r_state, n_state;
    t_func               r_func, n_func;
    logic [HEIGHT_W-1:0] r_bh, n_bh;
    logic [HEIGHT_W-1:0] r_ch, n_ch;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic                r_zone, n_zone;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]    r_rd_addr, n_rd_addr;
    logic                r_found, n_found;
    logic [HEIGHT_W-1:0] r_best, n_best;
    logic [IDX_W-1:0]    r_match, n_match;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [HEIGHT_W-1:0] r_highest, n_highest;
    logic [FD_W-1:0]     r_fd, n_fd;
    t_result             r_res, n_res;
    logic                r_out_vld, n_out_vld;
    t_result             r_out, n_out;

    logic                tbl_we;
    logic [HEIGHT_W-1:0] h_rdata;
    logic [HASH_W-1:0]   hash_rdata;
    logic                scan_done;
    logic                too_deep;
    logic                in_acc;
    logic                apb_wr;

    ctv_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_bh),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (h_rdata)
    );

    ctv_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_hash),
        .i_raddr (r_match),
        .o_rdata (hash_rdata)
    );

    assign in_acc    = i_in.valid && i_in.ready;
    assign scan_done = (r_rd_idx == r_count) && !r_rd_vld;
    assign too_deep  = ({1'b0, r_bh} + (HEIGHT_W+1)'(r_fd)) < {1'b0, r_ch};

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid         = r_out_vld;
    assign o_out.ok            = r_out.ok;
    assign o_out.is_checkpoint = r_out.is_checkpoint;
    assign o_out.in_zone       = r_out.in_zone;
    assign o_out.reason        = r_out.reason;

    // APB
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_FINALITY_DEPTH);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_FINALITY_DEPTH)
                    ? APB_DATA_W'(r_fd) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    if (r_func == FUNC_CHECK && r_found) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_HASH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath
    always_comb begin
        n_func    = r_func;
        n_bh      = r_bh;
        n_ch      = r_ch;
        n_hash    = r_hash;
        n_zone    = r_zone;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = 1'b0;
        n_rd_addr = r_rd_addr;
        n_found   = r_found;
        n_best    = r_best;
        n_match   = r_match;
        n_count   = r_count;
        n_highest = r_highest;
        n_fd      = apb_wr ? pwdata[FD_W-1:0] : r_fd;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_out.ready;
        tbl_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func   = i_in.func;
                    n_bh     = i_in.blk_height;
                    n_ch     = i_in.chain_height;
                    n_hash   = {i_in.hash_w3, i_in.hash_w2, i_in.hash_w1, i_in.hash_w0};
                    n_zone   = (r_count != '0) && (i_in.blk_height <= r_highest);
                    n_rd_idx = '0;
                    n_found  = 1'b0;
                    n_best   = '0;
                    n_match  = '0;
                end
            end
            S_SCAN: begin
                if (r_rd_idx != r_count) begin
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_rd_idx[IDX_W-1:0];
                end
                if (r_rd_vld) begin
                    if (r_func == FUNC_ALT) begin
                        if (h_rdata <= r_ch && (!r_found || h_rdata > r_best)) begin
                            n_found = 1'b1;
                            n_best  = h_rdata;
                        end
                    end else if (h_rdata == r_bh && !r_found) begin
                        n_found = 1'b1;
                        n_match = r_rd_addr;
                    end
                end
                if (scan_done) begin
                    n_res = '{ok: 1'b0, is_checkpoint: 1'b0, in_zone: r_zone,
                              reason: REASON_NONE};
                    unique case (r_func)
                        FUNC_ADD: begin
                            if (r_found) begin
                                n_res.reason = REASON_DUP;
                            end else if (r_count == CNT_FULL) begin
                                n_res.reason = REASON_FULL;
                            end else begin
                                tbl_we   = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                n_res.ok = 1'b1;
                                if (r_count == '0 || r_bh > r_highest) begin
                                    n_highest = r_bh;
                                end
                            end
                        end
                        FUNC_CHECK: begin
                            n_res.ok = !r_found;
                        end
                        FUNC_ALT: begin
                            if (r_bh == '0) begin
                                n_res.reason = REASON_GENESIS;
                            end else if (too_deep && !r_zone) begin
                                n_res.reason = REASON_DEEP;
                            end else if (r_found && !(r_best < r_bh)) begin
                                n_res.reason = REASON_BELOW_CP;
                            end else begin
                                n_res.ok = 1'b1;
                            end
                        end
                        FUNC_RSVD: begin
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_res.is_checkpoint = 1'b1;
                if (hash_rdata == r_hash) begin
                    n_res.ok = 1'b1;
                end else begin
                    n_res.reason = REASON_MISMATCH;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_highest <= '0;
            r_fd      <= FD_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_count   <= n_count;
            r_highest <= n_highest;
            r_fd      <= n_fd;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_bh      <= n_bh;
        r_ch      <= n_ch;
        r_hash    <= n_hash;
        r_zone    <= n_zone;
        r_rd_idx  <= n_rd_idx;
        r_rd_addr <= n_rd_addr;
        r_found   <= n_found;
        r_best    <= n_best;
        r_match   <= n_match;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

FILE: rtl/ctv_ram.sv
// ----------------------------------------------------------------------------
// ctv_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctv_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ctv_checker.sv
// ----------------------------------------------------------------------------
// ctv_checker
// Port-level checks on the checkpoint table validator.
// ----------------------------------------------------------------------------
module ctv_checker import ctv_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input logic    i_ok,
    input logic    i_is_cp,
    input logic    i_in_zone,
    input t_reason i_reason
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ok)
            && $stable(i_is_cp) && $stable(i_in_zone) && $stable(i_reason))
        else $error("result word changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    a_ok_no_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ok |-> i_reason == REASON_NONE)
        else $error("accepted result carries a reason");

    // a stored checkpoint lies at or below the highest one
    a_cp_in_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_cp |-> i_in_zone)
        else $error("checkpoint hit outside the zone");

    a_cp_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_cp |-> i_ok || i_reason == REASON_MISMATCH)
        else $error("checkpoint hit with wrong outcome");

endmodule

bind checkpoint_table_validator ctv_checker u_ctv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ok        (o_out.ok),
    .i_is_cp     (o_out.is_checkpoint),
    .i_in_zone   (o_out.in_zone),
    .i_reason    (o_out.reason)
);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the checkpoint table validator. Query words go in through a
// valid/ready channel that bursts and idles at random. Verdict words come back
// through a sink that stalls in patterns of its own. A scoreboard class keeps
// its own copy of the checkpoint table. It predicts every verdict word and
// checks each field. Directed queries cover genesis, depth boundaries,
// duplicates and hash mismatches. Random phases then run at several finality
// depths, fill the table to capacity and keep running on the full table.
// ----------------------------------------------------------------------------
module tb;
    import ctv_pkg::*;

    typedef logic [3:0][HASH_WORD_W-1:0] t_hash;

    typedef struct {
        t_func               func;
        logic [HEIGHT_W-1:0] blk_height;
        logic [HEIGHT_W-1:0] chain_height;
        t_hash               hash;
    } t_query;

    typedef enum int {PLAN_DIRECTED, PLAN_RANDOM, PLAN_FILL} t_plan;
    typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY} t_stall;

    class checkpoint_mirror;
        logic [HEIGHT_W-1:0] heights[$];
        t_hash               hashes[$];
        logic [HEIGHT_W-1:0] highest;
        logic [FD_W-1:0]     depth;
        t_result             awaited_verdicts[$];
        int unsigned         mismatches;
        int unsigned         queries;
        int unsigned         verdicts;
        int unsigned         reason_hits[8];

        function new();
            highest    = '0;
            depth      = FD_RESET;
            mismatches = 0;
            queries    = 0;
            verdicts   = 0;
            foreach (reason_hits[i]) reason_hits[i] = 0;
        endfunction

        function int find(logic [HEIGHT_W-1:0] h);
            foreach (heights[i]) begin
                if (heights[i] == h) return i;
            end
            return -1;
        endfunction

        function void note_query(t_query q);
            t_result             v;
            int                  idx;
            bit                  found;
            logic [HEIGHT_W-1:0] best;
            v.ok            = 1'b0;
            v.is_checkpoint = 1'b0;
            v.in_zone       = (heights.size() != 0) && (q.blk_height <= highest);
            v.reason        = REASON_NONE;
            idx             = find(q.blk_height);
            found           = 1'b0;
            best            = '0;
            case (q.func)
                FUNC_ADD: begin
                    if (idx >= 0) begin
                        v.reason = REASON_DUP;
                    end else if (heights.size() >= TABLE_ENTRIES_DEF) begin
                        v.reason = REASON_FULL;
                    end else begin
                        if (heights.size() == 0 || q.blk_height > highest)
                            highest = q.blk_height;
                        heights = {heights, q.blk_height};
                        hashes  = {hashes, q.hash};
                        v.ok = 1'b1;
                    end
                end
                FUNC_CHECK: begin
                    if (idx < 0) begin
                        v.ok = 1'b1;
                    end else begin
                        v.is_checkpoint = 1'b1;
                        if (hashes[idx] == q.hash) v.ok = 1'b1;
                        else v.reason = REASON_MISMATCH;
                    end
                end
                FUNC_ALT: begin
                    if (q.blk_height == '0) begin
                        v.reason = REASON_GENESIS;
                    end else if (({1'b0, q.blk_height} + {17'd0, depth})
                                 < {1'b0, q.chain_height} && !v.in_zone) begin
                        v.reason = REASON_DEEP;
                    end else begin
                        foreach (heights[i]) begin
                            if (heights[i] <= q.chain_height && (!found || heights[i] > best)) begin
                                best  = heights[i];
                                found = 1'b1;
                            end
                        end
                        if (!found || best < q.blk_height) v.ok = 1'b1;
                        else v.reason = REASON_BELOW_CP;
                    end
                end
                default: ;
            endcase
            queries++;
            reason_hits[v.reason]++;
            awaited_verdicts = {awaited_verdicts, v};
        endfunction

        function void report(string field, int want, int got);
            mismatches++;
            $display("%0t: verdict %0d %s expected %0d actual %0d",
                     $time, verdicts, field, want, got);
        endfunction

        function void check_verdict(logic ok, logic is_cp, logic zone, t_reason reason);
            t_result want;
            if (awaited_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: verdict word with none expected, expected none actual %b%b%b/%0d",
                         $time, ok, is_cp, zone, reason);
                return;
            end
            want = awaited_verdicts.pop_front();
            verdicts++;
            if (ok !== want.ok) report("ok", want.ok, ok);
            if (is_cp !== want.is_checkpoint) report("is_checkpoint", want.is_checkpoint, is_cp);
            if (zone !== want.in_zone) report("in_zone", want.in_zone, zone);
            if (reason !== want.reason) report("reason", want.reason, reason);
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  sink_ready = 1'b0;
    t_stall                stall_mode = STALL_NONE;
    int unsigned           stall_left = 0;
    int unsigned           burst_left = 0;
    t_query                directed_queue[$];
    checkpoint_mirror      board = new();

    ctv_in_if  query_if ();
    ctv_out_if verdict_if ();

    assign verdict_if.ready = sink_ready;

    checkpoint_table_validator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (query_if),
        .o_out   (verdict_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // verdict sink: stall pattern switches to a random mode when its run counter expires
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (verdict_if.valid && verdict_if.ready)
                board.check_verdict(verdict_if.ok, verdict_if.is_checkpoint,
                                    verdict_if.in_zone, verdict_if.reason);
            if (stall_left == 0) begin
                stall_mode <= t_stall'($urandom_range(0, 2));
                stall_left <= $urandom_range(40, 400);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                STALL_NONE: sink_ready <= 1'b1;
                STALL_COIN: sink_ready <= $urandom_range(0, 1);
                default:    sink_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        #10_000_000;
        $display("timeout: verdicts still outstanding or sender stuck");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_hash random_hash();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_query make_query(t_func f, logic [HEIGHT_W-1:0] bh,
                                          logic [HEIGHT_W-1:0] ch, t_hash h);
        t_query q;
        q.func         = f;
        q.blk_height   = bh;
        q.chain_height = ch;
        q.hash         = h;
        return q;
    endfunction

    function automatic void enqueue_directed(t_query q);
        directed_queue = {directed_queue, q};
    endfunction

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 24);
        return $urandom_range(1, 12);
    endfunction

    function automatic t_query random_query();
        t_query              q;
        int unsigned         n;
        int unsigned         idx;
        int unsigned         pick;
        int unsigned         sub;
        logic [HEIGHT_W-1:0] top;
        n    = board.heights.size();
        idx  = (n != 0) ? $urandom_range(0, n - 1) : 0;
        top  = board.highest;
        q    = make_query(FUNC_RSVD, $urandom, $urandom, random_hash());
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 5);
        if (pick < 28) begin
            q.func = FUNC_ADD;
            if (n != 0 && sub == 0) q.blk_height = board.heights[idx];
            else q.blk_height = $urandom_range(0, 32'h000F_FFFF);
        end else if (pick < 58) begin
            q.func = FUNC_CHECK;
            if (n != 0 && sub < 4) begin
                q.blk_height = board.heights[idx];
                q.hash       = board.hashes[idx];
                if (sub >= 2)
                    q.hash[$urandom_range(0, 3)][$urandom_range(0, 63)] ^= 1'b1;
            end else if (sub == 4) begin
                q.blk_height = $urandom_range(0, 32'h000F_FFFF);
            end
        end else if (pick < 95) begin
            q.func = FUNC_ALT;
            case (sub)
                0: q.blk_height = '0;
                1: begin
                    q.blk_height   = board.heights[idx] + $urandom_range(0, 2) - 1;
                    q.chain_height = board.heights[idx] + $urandom_range(0, 3000);
                end
                2: begin
                    q.blk_height   = top + $urandom_range(1, 500);
                    q.chain_height = q.blk_height + board.depth + $urandom_range(0, 2) - 1;
                end
                3: begin
                    q.blk_height   = top + $urandom_range(1, 100000);
                    q.chain_height = q.blk_height + $urandom_range(0, 200000);
                end
                4: ;
                default: begin
                    q.blk_height   = $urandom_range(1, 2000);
                    q.chain_height = board.heights[idx] - 1;
                end
            endcase
        end
        return q;
    endfunction

    function automatic t_query fill_query();
        t_query q;
        q = make_query(FUNC_ADD, 32'hFFFF_FFFF, $urandom, random_hash());
        if (board.heights.size() < TABLE_ENTRIES_DEF - 1) begin
            do q.blk_height = $urandom_range(0, 32'h000F_FFFF);
            while (board.find(q.blk_height) >= 0);
        end
        return q;
    endfunction

    task automatic send_query(input t_query q, input bit keep_valid);
        query_if.valid        <= 1'b1;
        query_if.func         <= q.func;
        query_if.blk_height   <= q.blk_height;
        query_if.chain_height <= q.chain_height;
        query_if.hash_w0      <= q.hash[0];
        query_if.hash_w1      <= q.hash[1];
        query_if.hash_w2      <= q.hash[2];
        query_if.hash_w3      <= q.hash[3];
        do @(posedge i_clk); while (query_if.ready !== 1'b1);
        board.note_query(q);
        if (!keep_valid) query_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.awaited_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_finality_depth(input logic [FD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FINALITY_DEPTH, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.depth = value;
    endtask

    task automatic run_queries(input int count, input t_plan plan);
        t_query q;
        int     gap;
        bit     hold_off;
        for (int i = 0; i < count; i++) begin
            case (plan)
                PLAN_DIRECTED: q = directed_queue.pop_front();
                PLAN_FILL:     q = fill_query();
                default:       q = random_query();
            endcase
            hold_off = ($urandom_range(0, 149) == 0);
            gap      = next_gap();
            send_query(q, (i != count - 1) && gap == 0 && !hold_off);
            if (hold_off) wait_drained();
            repeat (gap) @(posedge i_clk);
        end
        wait_drained();
    endtask

    initial begin
        t_hash key_hash;
        t_hash bent;
        query_if.valid        <= 1'b0;
        query_if.func         <= FUNC_ADD;
        query_if.blk_height   <= '0;
        query_if.chain_height <= '0;
        query_if.hash_w0      <= '0;
        query_if.hash_w1      <= '0;
        query_if.hash_w2      <= '0;
        query_if.hash_w3      <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table at reset depth, then a few checkpoints
        key_hash = random_hash();
        enqueue_directed(make_query(FUNC_ALT, 0, 5, '0));
        enqueue_directed(make_query(FUNC_CHECK, 5, 0, key_hash));
        enqueue_directed(make_query(FUNC_ALT, 1, 32'hFFFF_FFFF, '0));
        enqueue_directed(make_query(FUNC_ALT, 32'hFFFF_FFFF, 0, '0));
        enqueue_directed(make_query(FUNC_RSVD, 7, 9, '1));
        enqueue_directed(make_query(FUNC_ALT, 100, 110, '0));
        enqueue_directed(make_query(FUNC_ALT, 100, 111, '0));
        enqueue_directed(make_query(FUNC_ADD, 0, 0, '1));
        enqueue_directed(make_query(FUNC_ADD, 0, 0, '0));
        enqueue_directed(make_query(FUNC_ADD, 1000, 0, key_hash));
        enqueue_directed(make_query(FUNC_CHECK, 1000, 0, key_hash));
        bent = key_hash;
        bent[0][0] ^= 1'b1;
        enqueue_directed(make_query(FUNC_CHECK, 1000, 0, bent));
        bent = key_hash;
        bent[3][63] ^= 1'b1;
        enqueue_directed(make_query(FUNC_CHECK, 1000, 0, bent));
        enqueue_directed(make_query(FUNC_CHECK, 0, 0, '1));
        enqueue_directed(make_query(FUNC_ALT, 1000, 2000, '0));
        enqueue_directed(make_query(FUNC_ALT, 1001, 1012, '0));
        enqueue_directed(make_query(FUNC_ALT, 1001, 1011, '0));
        enqueue_directed(make_query(FUNC_ALT, 500, 999, '0));
        enqueue_directed(make_query(FUNC_RSVD, 1000, 0, '0));
        enqueue_directed(make_query(FUNC_CHECK, 32'hFFFF_FFFF, 0, '0));
        run_queries(directed_queue.size(), PLAN_DIRECTED);

        // depth extremes: sum must not wrap at 32 bits
        write_finality_depth(16'hFFFF);
        enqueue_directed(make_query(FUNC_ALT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '0));
        enqueue_directed(make_query(FUNC_ALT, 2000, 67536, '0));
        run_queries(directed_queue.size(), PLAN_DIRECTED);
        write_finality_depth(16'h0000);
        enqueue_directed(make_query(FUNC_ALT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '0));
        enqueue_directed(make_query(FUNC_ALT, 2000, 2001, '0));
        enqueue_directed(make_query(FUNC_ALT, 2000, 2000, '0));
        run_queries(directed_queue.size(), PLAN_DIRECTED);

        write_finality_depth(FD_W'($urandom_range(1, 64)));
        run_queries(300, PLAN_RANDOM);
        write_finality_depth(16'hFFFF);
        run_queries(300, PLAN_RANDOM);
        write_finality_depth(16'h0000);
        run_queries(300, PLAN_RANDOM);
        run_queries(TABLE_ENTRIES_DEF - board.heights.size(), PLAN_FILL);
        write_finality_depth(FD_W'($urandom));
        run_queries(450, PLAN_RANDOM);

        repeat (300) @(posedge i_clk);
        $display("covered %0d queries, %0d verdict words, table at %0d of %0d checkpoints",
                 board.queries, board.verdicts, board.heights.size(), TABLE_ENTRIES_DEF);
        $display("reasons none/dup/full/mismatch/genesis/deep/below: %0d %0d %0d %0d %0d %0d %0d",
                 board.reason_hits[REASON_NONE], board.reason_hits[REASON_DUP],
                 board.reason_hits[REASON_FULL], board.reason_hits[REASON_MISMATCH],
                 board.reason_hits[REASON_GENESIS], board.reason_hits[REASON_DEEP],
                 board.reason_hits[REASON_BELOW_CP]);
        if (board.mismatches == 0 && board.awaited_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/ctv_pkg.sv
rtl/ctv_if.sv
rtl/ctv_ram.sv
rtl/checkpoint_table_validator.sv
rtl/ctv_checker.sv
dv/tb.sv
